// File: design/tvsp_pkg.sv
// ----------------------------------------------------------------------------
// tvsp_pkg
// Shared types and codes of the tagged value stream parser: token kinds,
// error codes, tag bytes and the request record passed from front to back.
// ----------------------------------------------------------------------------
package tvsp_pkg;

  // signed balance count width
  localparam int BALANCE_BITS = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // tag bytes
  localparam logic [7:0] TAG_TABLE   = 8'd1;
  localparam logic [7:0] TAG_NUMBER  = 8'd2;
  localparam logic [7:0] TAG_STRING  = 8'd3;
  localparam logic [7:0] TAG_BOOLEAN = 8'd4;
  localparam logic [7:0] TAG_SETTAB  = 8'd5;
  localparam logic [7:0] TAG_LSTRING = 8'd6;
  localparam logic [7:0] TAG_PAD     = 8'd255;

  // token kinds
  localparam logic [2:0] KIND_TABLE    = 3'd0;
  localparam logic [2:0] KIND_NUMBER   = 3'd1;
  localparam logic [2:0] KIND_BOOLEAN  = 3'd2;
  localparam logic [2:0] KIND_STR_HEAD = 3'd3;
  localparam logic [2:0] KIND_STR_BYTE = 3'd4;
  localparam logic [2:0] KIND_SET      = 3'd5;
  localparam logic [2:0] KIND_END_OK   = 3'd6;
  localparam logic [2:0] KIND_ERROR    = 3'd7;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TRUNC_NUM  = 3'd1;
  localparam logic [2:0] ERR_TRUNC_LSTR = 3'd2;
  localparam logic [2:0] ERR_TRUNC_STR  = 3'd3;
  localparam logic [2:0] ERR_TRUNC_BOOL = 3'd4;
  localparam logic [2:0] ERR_BAD_TAG    = 3'd5;
  localparam logic [2:0] ERR_SURPLUS    = 3'd6;
  localparam logic [2:0] ERR_DEFICIT    = 3'd7;

  // one queued request: an optional value token, then an optional closing result
  typedef struct packed {
    logic        has_token;
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  code;
    logic        last;
    logic        has_close;
    logic [2:0]  close_code;
  } tvsp_req_t;

endpackage

// File: design/tvsp_queue.sv
// ----------------------------------------------------------------------------
// tvsp_queue
// Short request queue between the parsing front and the token back end.
// ----------------------------------------------------------------------------
module tvsp_queue
  import tvsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tvsp_req_t push_req,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output tvsp_req_t head_req
);

  tvsp_req_t            slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  // status
  assign full      = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_req  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !(push && !pop))
    else $error("push into full queue");

endmodule

// File: design/tvsp_front.sv
// ----------------------------------------------------------------------------
// tvsp_front
// Accepts buffer bytes, tracks the parse phase, assembles fields, keeps the
// saturating balance count and queues the tokens that each byte produces.
// ----------------------------------------------------------------------------
module tvsp_front
  import tvsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       queue_full,
  output logic       push,
  output tvsp_req_t  push_req
);

  typedef enum logic [2:0] {
    PH_TAG, PH_NUM, PH_SLEN, PH_LLEN, PH_SBYTES, PH_LBYTES, PH_BOOL
  } phase_t;

  localparam logic signed [BALANCE_BITS-1:0] BAL_MAX = {1'b0, {(BALANCE_BITS-1){1'b1}}};
  localparam logic signed [BALANCE_BITS-1:0] BAL_MIN = {1'b1, {(BALANCE_BITS-1){1'b0}}};
  localparam logic signed [BALANCE_BITS:0]   SUM_MAX = (BALANCE_BITS+1)'(BAL_MAX);
  localparam logic signed [BALANCE_BITS:0]   SUM_MIN = (BALANCE_BITS+1)'(BAL_MIN);

  phase_t                          phase, phase_next;
  logic [2:0]                      cnt, cnt_next;
  logic [63:0]                     asm_val, asm_next;
  logic [31:0]                     left, left_next;
  logic signed [BALANCE_BITS-1:0]  bal, bal_next;
  logic                            stopped, stopped_next;
  logic [63:0]                     merged;
  logic [2:0]                      last_cnt;
  logic [31:0]                     left_dec;
  logic                            err;
  logic                            accept;
  tvsp_req_t                       req;

  // saturating balance update
  function automatic logic signed [BALANCE_BITS-1:0] bal_sat(
    input logic signed [BALANCE_BITS-1:0] cur,
    input logic signed [2:0]              delta
  );
    logic signed [BALANCE_BITS:0] sum;
    sum = (BALANCE_BITS+1)'(cur) + (BALANCE_BITS+1)'(delta);
    if (sum > SUM_MAX) begin
      return BAL_MAX;
    end else if (sum < SUM_MIN) begin
      return BAL_MIN;
    end
    return sum[BALANCE_BITS-1:0];
  endfunction

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign push       = accept && (req.has_token || req.has_close);
  assign push_req   = req;

  // field assembly lanes
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      merged[8*i +: 8] = (cnt == 3'(i)) ? data_byte : asm_val[8*i +: 8];
    end
  end

  assign left_dec = (left != '0) ? left - 32'd1 : left;

  // parse step
  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    asm_next     = asm_val;
    left_next    = left;
    bal_next     = bal;
    stopped_next = stopped;
    err          = 1'b0;
    req          = '0;
    last_cnt     = 3'd7;
    if (stopped) begin
      // last byte of the buffer re-arms with a clean state
      if (final_byte) begin
        stopped_next = 1'b0;
        phase_next   = PH_TAG;
        cnt_next     = '0;
        asm_next     = '0;
        left_next    = '0;
        bal_next     = '0;
      end
    end else begin
      case (phase)
        PH_TAG: begin
          case (data_byte)
            TAG_PAD: begin
            end
            TAG_TABLE: begin
              req.has_token = 1'b1;
              req.kind      = KIND_TABLE;
              bal_next      = bal_sat(bal, 3'sd1);
            end
            TAG_NUMBER, TAG_STRING, TAG_LSTRING: begin
              phase_next = (data_byte == TAG_NUMBER) ? PH_NUM :
                           (data_byte == TAG_STRING) ? PH_SLEN : PH_LLEN;
              cnt_next   = '0;
              asm_next   = '0;
            end
            TAG_BOOLEAN: begin
              phase_next = PH_BOOL;
            end
            TAG_SETTAB: begin
              req.has_token = 1'b1;
              req.kind      = KIND_SET;
              bal_next      = bal_sat(bal, -3'sd2);
            end
            default: begin
              req.has_token = 1'b1;
              req.kind      = KIND_ERROR;
              req.code      = ERR_BAD_TAG;
              req.last      = final_byte;
              err           = 1'b1;
            end
          endcase
        end
        PH_NUM, PH_SLEN, PH_LLEN: begin
          last_cnt = (phase == PH_NUM) ? 3'd7 : (phase == PH_SLEN) ? 3'd1 : 3'd3;
          if (cnt >= last_cnt) begin
            req.has_token = 1'b1;
            if (phase == PH_NUM) begin
              req.kind   = KIND_NUMBER;
              req.value  = merged;
              phase_next = PH_TAG;
            end else begin
              req.kind  = KIND_STR_HEAD;
              req.value = {32'd0, merged[31:0]};
              left_next = merged[31:0];
              if (merged[31:0] == '0) begin
                phase_next = PH_TAG;
              end else begin
                phase_next = (phase == PH_SLEN) ? PH_SBYTES : PH_LBYTES;
              end
            end
            bal_next = bal_sat(bal, 3'sd1);
            cnt_next = '0;
            asm_next = '0;
          end else begin
            cnt_next = cnt + 3'd1;
            asm_next = merged;
          end
        end
        PH_SBYTES, PH_LBYTES: begin
          req.has_token = 1'b1;
          req.kind      = KIND_STR_BYTE;
          req.value     = {56'd0, data_byte};
          left_next     = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_TAG;
          end
        end
        PH_BOOL: begin
          req.has_token = 1'b1;
          req.kind      = KIND_BOOLEAN;
          req.value     = {56'd0, data_byte};
          bal_next      = bal_sat(bal, 3'sd1);
          phase_next    = PH_TAG;
        end
        default: begin
          phase_next = PH_TAG;
        end
      endcase

      // buffer close
      if (err) begin
        if (!final_byte) begin
          stopped_next = 1'b1;
        end
      end else if (final_byte) begin
        req.has_close = 1'b1;
        case (phase_next)
          PH_TAG: begin
            req.close_code = (bal_next > 0) ? ERR_SURPLUS :
                             (bal_next < 0) ? ERR_DEFICIT : ERR_NONE;
          end
          PH_NUM:              req.close_code = ERR_TRUNC_NUM;
          PH_LLEN, PH_LBYTES:  req.close_code = ERR_TRUNC_LSTR;
          PH_SLEN, PH_SBYTES:  req.close_code = ERR_TRUNC_STR;
          default:             req.close_code = ERR_TRUNC_BOOL;
        endcase
      end
      if (final_byte) begin
        phase_next = PH_TAG;
        cnt_next   = '0;
        asm_next   = '0;
        left_next  = '0;
        bal_next   = '0;
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_TAG;
      cnt     <= '0;
      asm_val <= '0;
      left    <= '0;
      bal     <= '0;
      stopped <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      asm_val <= asm_next;
      left    <= left_next;
      bal     <= bal_next;
      stopped <= stopped_next;
    end
  end

  a_stop_at_tag: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (phase == PH_TAG))
    else $error("stopped outside tag phase");

  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |=> (phase == PH_TAG && bal == '0 && !stopped))
    else $error("state not cleared after buffer close");

endmodule

// File: design/tvsp_back.sv
// ----------------------------------------------------------------------------
// tvsp_back
// Takes queued requests and delivers them as result tokens through an
// output register, sending a closing result after its value token.
// ----------------------------------------------------------------------------
module tvsp_back
  import tvsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        queue_not_empty,
  input  tvsp_req_t   head_req,
  output logic        pop,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [2:0]  token_kind,
  output logic [63:0] token_value,
  output logic [2:0]  error_code,
  output logic        run_last
);

  logic       pend_valid;
  logic [2:0] pend_code;
  logic       out_free;

  assign out_free = !token_valid || token_ready;
  assign pop      = queue_not_empty && !pend_valid && out_free;

  // output register and pending closing result
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      pend_valid  <= 1'b0;
      pend_code   <= ERR_NONE;
      token_kind  <= KIND_TABLE;
      token_value <= '0;
      error_code  <= ERR_NONE;
      run_last    <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        token_valid <= 1'b1;
        token_kind  <= (pend_code == ERR_NONE) ? KIND_END_OK : KIND_ERROR;
        token_value <= '0;
        error_code  <= pend_code;
        run_last    <= 1'b1;
        pend_valid  <= 1'b0;
      end else if (queue_not_empty) begin
        token_valid <= 1'b1;
        if (head_req.has_token) begin
          token_kind  <= head_req.kind;
          token_value <= head_req.value;
          error_code  <= head_req.code;
          run_last    <= head_req.last;
          pend_valid  <= head_req.has_close;
          pend_code   <= head_req.close_code;
        end else begin
          token_kind  <= (head_req.close_code == ERR_NONE) ? KIND_END_OK : KIND_ERROR;
          token_value <= '0;
          error_code  <= head_req.close_code;
          run_last    <= 1'b1;
        end
      end else begin
        token_valid <= 1'b0;
      end
    end
  end

  a_pend_has_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> token_valid)
    else $error("pending close without a token in the output register");

  a_close_follows: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && token_ready) |=> (token_valid && run_last &&
      (token_kind == KIND_END_OK || token_kind == KIND_ERROR)))
    else $error("closing result did not follow its value token");

endmodule

// File: design/tagged_value_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// tagged_value_stream_parser_unit
// Byte-serial parser of a tagged nested-table buffer.
// ----------------------------------------------------------------------------
// Input channel: byte_valid/byte_ready with data_byte and final_byte; one
// buffer byte per request, final_byte marks the buffer's last byte.
// Output channel: token_valid/token_ready with token_kind, token_value,
// error_code and run_last; one token per request.
// A byte is taken in every cycle while the four-entry request queue has
// room. Each byte yields zero, one or two tokens; the second one (end ok
// or error closing the buffer) is held pending and goes out as the next
// token. An accepted byte's first token is registered in the queue, then
// in the output register. Sustained rate is one byte and one token per
// cycle while token_ready stays high and the queue has room; a final byte
// with a value token plus its closing result sends both, value first.
// When token_ready is low the output register holds, the queue fills and
// byte_ready drops once it is full. Reset clears parse state, balance
// count and queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tagged_value_stream_parser_unit
  import tvsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [2:0]  token_kind,
  output logic [63:0] token_value,
  output logic [2:0]  error_code,
  output logic        run_last
);

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_not_empty;
  tvsp_req_t q_in;
  tvsp_req_t q_head;

  // parsing front
  tvsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .queue_full (q_full),
    .push       (q_push),
    .push_req   (q_in)
  );

  // request queue
  tvsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_req  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_req  (q_head)
  );

  // token back end
  tvsp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (q_not_empty),
    .head_req        (q_head),
    .pop             (q_pop),
    .token_valid     (token_valid),
    .token_ready     (token_ready),
    .token_kind      (token_kind),
    .token_value     (token_value),
    .error_code      (error_code),
    .run_last        (run_last)
  );

endmodule
